### rtl/jddm_pkg.sv
// Shared types and constants for the joystick differential drive mixer.
// No dependencies; used by the top level.
`default_nettype none

package jddm_pkg;

    localparam int POS_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ZONE = 1'd1;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam int AXIS_FULL   = 255;
    localparam int AXIS_SCALE  = 510;
    localparam int ADC_MAX     = 1023;
    localparam int DIAG_MARGIN = 10;

    typedef struct packed {
        logic [POS_W-1:0]  x_position;
        logic [POS_W-1:0]  y_position;
        logic              ignition_in;
        logic [BYTE_W-1:0] accelerator_in;
    } t_joy_in;

    typedef struct packed {
        logic              left_fwd;
        logic              left_rev;
        logic [BYTE_W-1:0] left_duty;
        logic              right_fwd;
        logic              right_rev;
        logic [BYTE_W-1:0] right_duty;
        logic              ignition_out;
        logic [BYTE_W-1:0] accelerator_out;
    } t_mix_out;

endpackage

`default_nettype wire

### rtl/jddm_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; the mixer uses types from jddm_pkg.
`default_nettype none

interface jddm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/joystick_differential_drive_mixer_top.sv
// Joystick differential drive mixer: axis conditioning and arcade-drive mixing.
// Pipeline: the input transfer is captured in the input reg, then the mixed result
// in the result reg, which holds it until the output transfer.
// Throughput: one sample per cycle while o_mix is ready; an empty input register fills while a result waits.
// Reset (synchronous, active low) clears the valid flags of both stages, the motor state and the
// dead/edge zone registers. Depends on jddm_pkg and jddm_stream_if.
`default_nettype none

module joystick_differential_drive_mixer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jddm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jddm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    jddm_stream_if.sink                     i_joy,
    jddm_stream_if.source                   o_mix
);
    import jddm_pkg::*;

    function automatic logic signed [8:0] f_axis(
        input logic [POS_W-1:0]  raw,
        input logic [BYTE_W-1:0] dz,
        input logic [BYTE_W-1:0] ez
    );
        logic [18:0]       prod;
        logic [8:0]        q0;
        logic [10:0]       rem;
        logic [9:0]        q;
        logic signed [9:0] v;
        logic [7:0]        m;
        logic signed [8:0] res;
        prod = 19'(raw) * 19'(AXIS_SCALE);
        // divide by 1023: p = 1024*q0 + lo = 1023*q0 + (q0 + lo)
        q0   = prod[18:10];
        rem  = 11'(prod[9:0]) + 11'(q0);
        q    = 10'(q0) + 10'(rem >= 11'(ADC_MAX));
        v    = signed'(q) - 10'sd255;
        m    = (v < 0) ? 8'(-v) : 8'(v);
        if (m < dz) begin
            res = 9'sd0;
        end else if (9'(m) > 9'(AXIS_FULL) - 9'(ez)) begin
            res = (v < 0) ? -9'sd255 : 9'sd255;
        end else begin
            res = v[8:0];
        end
        return res;
    endfunction

    logic [BYTE_W-1:0] r_dead_zone;
    logic [BYTE_W-1:0] r_edge_zone;

    logic              r_s1_valid;
    t_joy_in           r_s1;
    logic              r_out_valid;
    t_mix_out          r_out;

    logic [1:0]        r_ldir, r_rdir, n_ldir, n_rdir;
    logic [BYTE_W-1:0] r_lspd, r_rspd, n_lspd, n_rspd;

    logic              s1_advance;
    logic signed [8:0] x, y;
    logic [7:0]        ax, ay;
    logic signed [9:0] diff;
    logic [1:0]        ydir;

    assign s1_advance  = r_s1_valid && (!r_out_valid || o_mix.ready);
    assign i_joy.ready = !r_s1_valid || s1_advance;
    assign o_mix.valid = r_out_valid;
    assign o_mix.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= '0;
            r_edge_zone <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data;
                CFG_EDGE_ZONE: r_edge_zone <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb begin
        x    = f_axis(r_s1.x_position, r_dead_zone, r_edge_zone);
        y    = f_axis(r_s1.y_position, r_dead_zone, r_edge_zone);
        ax   = (x < 0) ? 8'(-x) : 8'(x);
        ay   = (y < 0) ? 8'(-y) : 8'(y);
        diff = signed'(10'(ay)) - signed'(10'(ax));
        ydir = (y > 0) ? DIR_FWD : DIR_REV;

        n_ldir = r_ldir;
        n_rdir = r_rdir;
        n_lspd = r_lspd;
        n_rspd = r_rspd;

        if (x == 0 && y == 0) begin
            n_ldir = DIR_STOP;
            n_rdir = DIR_STOP;
        end else if (diff > -10'(DIAG_MARGIN) && diff < 10'(DIAG_MARGIN)) begin
            if (x > 0) begin
                n_rdir = DIR_STOP;
                n_rspd = '0;
                if (y != 0) begin
                    n_ldir = ydir;
                    n_lspd = ay;
                end
            end else begin
                n_ldir = DIR_STOP;
                n_lspd = '0;
                if (y != 0) begin
                    n_rdir = ydir;
                    n_rspd = ay;
                end
            end
        end else if (ay > ax) begin
            n_ldir = ydir;
            n_rdir = ydir;
            if (x > 0) begin
                n_lspd = ay;
                n_rspd = ay - ax;
            end else begin
                n_rspd = ay;
                n_lspd = ay - ax;
            end
        end else begin
            if (x > 0) begin
                n_ldir = (y >= 0) ? DIR_FWD : DIR_REV;
                n_rdir = (y >= 0) ? DIR_REV : DIR_FWD;
                n_lspd = ax;
                n_rspd = ax - ay;
            end else begin
                n_ldir = (y >= 0) ? DIR_REV : DIR_FWD;
                n_rdir = (y >= 0) ? DIR_FWD : DIR_REV;
                n_rspd = ax;
                n_lspd = ax - ay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ldir      <= DIR_STOP;
            r_rdir      <= DIR_STOP;
            r_lspd      <= '0;
            r_rspd      <= '0;
        end else begin
            if (i_joy.valid && i_joy.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_ldir      <= n_ldir;
                r_rdir      <= n_rdir;
                r_lspd      <= n_lspd;
                r_rspd      <= n_rspd;
            end else if (o_mix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_joy.valid && i_joy.ready) begin
            r_s1 <= i_joy.data;
        end
        if (s1_advance) begin
            r_out.left_fwd        <= n_ldir[0];
            r_out.left_rev        <= n_ldir[1];
            r_out.left_duty       <= n_lspd;
            r_out.right_fwd       <= n_rdir[0];
            r_out.right_rev       <= n_rdir[1];
            r_out.right_duty      <= n_rspd;
            r_out.ignition_out    <= r_s1.ignition_in;
            r_out.accelerator_out <= r_s1.accelerator_in;
        end
    end

endmodule

`default_nettype wire
